/* hw/rtl/segment_to_quad_expander_macros.svh */
// Assertion helpers for the quad expander checker.
// Both expect clk and rst in the scope where they are used.
`ifndef SEGMENT_TO_QUAD_EXPANDER_MACROS_SVH
`define SEGMENT_TO_QUAD_EXPANDER_MACROS_SVH

// same-cycle implication
`define SQE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sqe checker: property failed");

// next-cycle implication
`define SQE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sqe checker: property failed");

`endif

/* hw/rtl/sqe_pkg.sv */
package sqe_pkg;

  localparam int COEF_FRAC = 12;
  localparam int VERTS     = 6;
  localparam int CFG_IDX_W = 3;

  localparam logic [2:0] LAST_SLOT = 3'(VERTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_ROW0  = 3'd0,
    REG_VIEW_ROW1  = 3'd1,
    REG_VIEW_ROW2  = 3'd2,
    REG_SHIFT_X    = 3'd3,
    REG_SHIFT_Y    = 3'd4,
    REG_SHIFT_Z    = 3'd5,
    REG_HALF_WIDTH = 3'd6
  } cfg_reg_t;

  // status of an iterative unit; done pulses one cycle with the result
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

/* hw/rtl/sqe_mul.sv */
// Shared signed 32x32 multiplier, product registered.
module sqe_mul (
  input  logic               clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

/* hw/rtl/sqe_isqrt.sv */
// Floor square root, two radicand bits per cycle.
module sqe_isqrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [61:0]         radicand,
  output logic [30:0]         root,
  output sqe_pkg::unit_stat_t stat
);
  import sqe_pkg::*;

  logic [62:0] rem;
  logic [62:0] res;
  logic [62:0] probe;
  logic [62:0] trial;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;

  assign trial = res + probe;
  assign root  = res[30:0];
  assign stat  = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= {1'b0, radicand};
      res   <= '0;
      probe <= 63'd1 << 62;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + probe;
      end else begin
        res <= res >> 1;
      end
      probe <= probe >> 2;
    end
  end

endmodule

/* hw/rtl/sqe_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module sqe_div #(
  parameter int DW = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DW-1:0]       num,
  input  logic [30:0]         den,
  output logic [DW-1:0]       quo,
  output sqe_pkg::unit_stat_t stat
);
  import sqe_pkg::*;

  localparam int CW = $clog2(DW);

  logic [30:0]   rem;
  logic [31:0]   shifted;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  assign shifted = {rem, quo[DW-1]};
  assign stat    = '{busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem <= 31'(shifted - {1'b0, den});
        quo <= {quo[DW-2:0], 1'b1};
      end else begin
        rem <= shifted[30:0];
        quo <= {quo[DW-2:0], 1'b0};
      end
    end
  end

endmodule

/* hw/rtl/segment_to_quad_expander.sv */
// A trail-start point only runs the transform, is stored as the previous point and returns to idle.
// A segment runs the 9-term transform, per end the range shifts, the 32-step square root and
// three FRAC_BITS+32 step divisions, then six vertex transactions, held while m_tready stalls.
// Throughput: one point at a time; s_tready is high only in the idle state.
// Reset (rst, synchronous): config to identity, no shift, half width 1.0; no previous point.
module segment_to_quad_expander #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sqe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [47:0]                    cfg_data,
  // point stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [95:0]                    s_tdata,   // pos_x, pos_y, pos_z
  input  logic [0:0]                     s_tuser,   // starts_trail
  // vertex stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [95:0]                    m_tdata,   // vert_x, vert_y, vert_z
  output logic [3:0]                     m_tuser,   // vertex_slot[2:0], degenerate
  output logic                           m_tlast
);
  import sqe_pkg::*;

  localparam int DW = FRAC_BITS + 32;   // divider dividend width
  localparam int NW = FRAC_BITS + 2;    // normal component, |n| <= 1.0

  typedef enum logic [3:0] {
    S_IDLE, S_XF, S_DIFF, S_LOAD, S_SHR, S_CR, S_NRM, S_SQ,
    S_SQRT, S_DIVGO, S_DIVW, S_OFF, S_OUT
  } state_t;

  state_t state;

  // configuration
  logic [47:0]        view_row [3];
  logic signed [31:0] shift_v [3];
  logic [30:0]        half_width;

  // point and segment state
  logic signed [31:0] pos [3];
  logic               starts;
  logic signed [31:0] e [3];
  logic signed [31:0] prev [3];
  logic               prev_valid;
  logic signed [32:0] dv [3];

  // transform sequencing: issue counters and their registered copies for the accumulate
  logic signed [50:0] acc;
  logic [1:0]         tr, tc, pr, pc;
  logic               iss, pv;

  // normal working set
  logic [2:0]         k;
  logic [2:0]         km1;
  logic               side;
  logic               zmode;
  logic               deg;
  logic signed [32:0] wd [3];
  logic signed [31:0] wp [3];
  logic signed [63:0] wc [3];
  logic [61:0]        ssum;
  logic [30:0]        len;
  logic signed [NW-1:0] nv [3];
  logic signed [32:0] off [2][3];
  logic [2:0]         slot;

  // shared units
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               sq_start;
  logic [61:0]        sq_rad;
  logic [30:0]        sq_root;
  unit_stat_t         sq_stat;
  logic               dv_start;
  logic [DW-1:0]      dv_num;
  logic [DW-1:0]      dv_quo;
  unit_stat_t         dv_stat;

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -51'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  sqe_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  sqe_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_rad),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  sqe_div #(.DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (len),
    .quo   (dv_quo),
    .stat  (dv_stat)
  );

  assign cfg_ready = (state == S_IDLE);
  assign s_tready  = (state == S_IDLE);
  assign km1       = k - 3'd1;

  // ---------------------------------------------------------------------------
  // Configuration registers; writes only land while idle.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      view_row[0] <= 48'd4096;
      view_row[1] <= 48'd4096 << 16;
      view_row[2] <= 48'd4096 << 32;
      shift_v[0]  <= '0;
      shift_v[1]  <= '0;
      shift_v[2]  <= '0;
      half_width  <= 31'd1 << FRAC_BITS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_VIEW_ROW0:  view_row[0] <= cfg_data;
        REG_VIEW_ROW1:  view_row[1] <= cfg_data;
        REG_VIEW_ROW2:  view_row[2] <= cfg_data;
        REG_SHIFT_X:    shift_v[0]  <= cfg_data[31:0];
        REG_SHIFT_Y:    shift_v[1]  <= cfg_data[31:0];
        REG_SHIFT_Z:    shift_v[2]  <= cfg_data[31:0];
        REG_HALF_WIDTH: half_width  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath helpers
  // ---------------------------------------------------------------------------
  logic [15:0]        coef;
  logic signed [50:0] xf_base, xf_sum;
  logic signed [31:0] xf_sat;
  logic signed [32:0] dd [3];
  logic               d_zero, d_in, p_in, c_in30, c_in29, c_zero;
  logic signed [63:0] c_sel, c_neg;
  logic [30:0]        c_mag;
  logic signed [NW-1:0] n_q, n_val;
  logic [63:0]        p_mag, off_m;
  logic signed [32:0] off_pos, off_val;
  logic               at_end, plus;
  logic signed [31:0] vtx [3];

  assign coef    = view_row[tr][{tc, 4'b0000} +: 16];
  assign xf_base = ({{19{shift_v[pr][31]}}, shift_v[pr]} <<< COEF_FRAC)
                   + 51'sd2048;
  assign xf_sum  = ((pc == 2'd0) ? xf_base : acc) + mul_p[50:0];
  assign xf_sat  = sat32(xf_sum >>> COEF_FRAC);

  always_comb begin
    d_zero = 1'b1;
    d_in   = 1'b1;
    p_in   = 1'b1;
    c_in30 = 1'b1;
    c_in29 = 1'b1;
    c_zero = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dd[i]  = {e[i][31], e[i]} - {prev[i][31], prev[i]};
      d_zero = d_zero && (dd[i] == '0);
      // inside [-2^30, 2^30): the top bits are all sign copies
      d_in   = d_in && ((wd[i][32:30] == 3'b000) || (wd[i][32:30] == 3'b111));
      p_in   = p_in && ((wp[i][31:30] == 2'b00) || (wp[i][31:30] == 2'b11));
      c_in30 = c_in30 && ((&wc[i][63:30]) || !(|wc[i][63:30]));
      c_in29 = c_in29 && ((&wc[i][63:29]) || !(|wc[i][63:29]));
      c_zero = c_zero && (wc[i] == '0);
    end
  end

  // divider feed: |c| * 2^FRAC + len/2, sign restored after
  assign c_sel  = wc[k[1:0]];
  assign c_neg  = -c_sel;
  assign c_mag  = c_sel[63] ? c_neg[30:0] : c_sel[30:0];
  assign dv_num = (DW'(c_mag) << FRAC_BITS) + DW'(len >> 1);
  assign n_q    = NW'(dv_quo);
  assign n_val  = c_sel[63] ? -n_q : n_q;
  assign dv_start = (state == S_DIVGO);

  // offset: n * half_width / 2^FRAC, rounded half away from zero
  assign p_mag   = mul_p[63] ? 64'(-mul_p) : 64'(mul_p);
  assign off_m   = (p_mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign off_pos = off_m[32:0];
  assign off_val = mul_p[63] ? -off_pos : off_pos;

  // square root starts as the last square lands
  assign sq_start = (state == S_SQ) && (k == 3'd3);
  assign sq_rad   = ssum + mul_p[61:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_XF: begin
        mul_a = {{16{coef[15]}}, coef};
        mul_b = pos[tc];
      end
      S_CR: begin
        case (k)
          3'd0: begin mul_a = wd[1][31:0]; mul_b = wp[2]; end
          3'd1: begin mul_a = wd[2][31:0]; mul_b = wp[1]; end
          3'd2: begin mul_a = wd[2][31:0]; mul_b = wp[0]; end
          3'd3: begin mul_a = wd[0][31:0]; mul_b = wp[2]; end
          3'd4: begin mul_a = wd[0][31:0]; mul_b = wp[1]; end
          3'd5: begin mul_a = wd[1][31:0]; mul_b = wp[0]; end
          default: ;
        endcase
      end
      S_SQ: begin
        if (k < 3'd3) begin
          mul_a = wc[k[1:0]][31:0];
          mul_b = wc[k[1:0]][31:0];
        end
      end
      S_OFF: begin
        if (k < 3'd3) begin
          mul_a = {{(32 - NW){nv[k[1:0]][NW-1]}}, nv[k[1:0]]};
          mul_b = {1'b0, half_width};
        end
      end
      default: ;
    endcase
  end

  // vertex for the current slot
  always_comb begin
    logic signed [33:0] sum;
    at_end = slot inside {3'd2, 3'd3, 3'd4};
    plus   = slot inside {3'd0, 3'd2, 3'd4};
    for (int i = 0; i < 3; i++) begin
      if (plus) begin
        sum = {{2{(at_end ? e[i][31] : prev[i][31])}}, (at_end ? e[i] : prev[i])}
              + {off[at_end][i][32], off[at_end][i]};
      end else begin
        sum = {{2{(at_end ? e[i][31] : prev[i][31])}}, (at_end ? e[i] : prev[i])}
              - {off[at_end][i][32], off[at_end][i]};
      end
      vtx[i] = zmode ? 32'sd0 : sat32({{17{sum[33]}}, sum});
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      prev_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev[i] <= '0;
      end
    end else begin
      // S_OUT decides m_tvalid itself
      if (m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              pos[i] <= s_tdata[32*i +: 32];
            end
            starts <= s_tuser[0];
            tr     <= '0;
            tc     <= '0;
            iss    <= 1'b1;
            pv     <= 1'b0;
            state  <= S_XF;
          end
        end
        S_XF: begin
          // nine coefficient terms, each accumulated in the cycle after its issue
          if (iss) begin
            if (tc == 2'd2) begin
              tc <= '0;
              if (tr == 2'd2) begin
                iss <= 1'b0;
              end else begin
                tr <= tr + 2'd1;
              end
            end else begin
              tc <= tc + 2'd1;
            end
          end
          pv <= iss;
          pr <= tr;
          pc <= tc;
          if (pv) begin
            if (pc == 2'd2) begin
              e[pr] <= xf_sat;
              if (pr == 2'd2) begin
                state <= S_DIFF;
              end
            end else begin
              acc <= xf_sum;
            end
          end
        end
        S_DIFF: begin
          if (starts || !prev_valid) begin
            prev       <= e;
            prev_valid <= 1'b1;
            state      <= S_IDLE;
          end else if (d_zero) begin
            // identical points: six zero vertices
            zmode <= 1'b1;
            deg   <= 1'b1;
            slot  <= '0;
            state <= S_OUT;
          end else begin
            dv    <= dd;
            zmode <= 1'b0;
            deg   <= 1'b0;
            side  <= 1'b0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            wd[i] <= dv[i];
            wp[i] <= side ? e[i] : prev[i];
          end
          state <= S_SHR;
        end
        S_SHR: begin
          if (!d_in) begin
            for (int i = 0; i < 3; i++) begin
              wd[i] <= wd[i] >>> 1;
            end
          end
          if (!p_in) begin
            for (int i = 0; i < 3; i++) begin
              wp[i] <= wp[i] >>> 1;
            end
          end
          if (d_in && p_in) begin
            k     <= '0;
            state <= S_CR;
          end
        end
        S_CR: begin
          // even terms open a component, odd terms subtract
          if (k != 3'd0) begin
            if (km1[0]) begin
              wc[km1[2:1]] <= wc[km1[2:1]] - mul_p;
            end else begin
              wc[km1[2:1]] <= mul_p;
            end
          end
          if (k == 3'd6) begin
            state <= S_NRM;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_NRM: begin
          if (c_zero) begin
            // zero cross product: zero normal, vertices sit on the point
            for (int i = 0; i < 3; i++) begin
              nv[i] <= '0;
            end
            deg   <= 1'b1;
            k     <= '0;
            state <= S_OFF;
          end else if (!c_in30) begin
            for (int i = 0; i < 3; i++) begin
              wc[i] <= wc[i] >>> 1;
            end
          end else if (c_in29) begin
            for (int i = 0; i < 3; i++) begin
              wc[i] <= wc[i] <<< 1;
            end
          end else begin
            ssum  <= '0;
            k     <= '0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (k != 3'd0) begin
            ssum <= ssum + mul_p[61:0];
          end
          if (k == 3'd3) begin
            state <= S_SQRT;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_SQRT: begin
          if (sq_stat.done) begin
            len   <= sq_root;
            k     <= '0;
            state <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state <= S_DIVW;
        end
        S_DIVW: begin
          if (dv_stat.done) begin
            nv[k[1:0]] <= n_val;
            if (k == 3'd2) begin
              k     <= '0;
              state <= S_OFF;
            end else begin
              k     <= k + 3'd1;
              state <= S_DIVGO;
            end
          end
        end
        S_OFF: begin
          if (k != 3'd0) begin
            off[side][km1[1:0]] <= off_val;
          end
          if (k == 3'd3) begin
            if (!side) begin
              side  <= 1'b1;
              state <= S_LOAD;
            end else begin
              slot  <= '0;
              state <= S_OUT;
            end
          end else begin
            k <= k + 3'd1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {vtx[2], vtx[1], vtx[0]};
            m_tuser  <= {deg, slot};
            m_tlast  <= (slot == LAST_SLOT);
            if (slot == LAST_SLOT) begin
              prev  <= e;
              state <= S_IDLE;
            end else begin
              slot <= slot + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/sqe_checker.sv */
`include "segment_to_quad_expander_macros.svh"

module sqe_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);
  import sqe_pkg::*;

  // stalled vertex holds
  `SQE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // tlast marks exactly the final slot
  `SQE_ASSERT_NOW(a_last_slot, m_tvalid, m_tlast == (m_tuser[2:0] == LAST_SLOT))

  // no new point while a segment is still going out
  `SQE_ASSERT_NOW(a_busy_out, m_tvalid && !m_tlast, !s_tready)

  // vertices of one segment come back to back in slot order
  `SQE_ASSERT_NEXT(a_slot_step, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser[2:0] == $past(m_tuser[2:0]) + 3'd1))

endmodule

bind segment_to_quad_expander sqe_checker u_sqe_checker (.*);
